>>> rtl/tce_pkg.sv
// Shared types and constants of the TCP echo connection engine.
`timescale 1ns / 1ps
package tce_pkg;
   localparam int MaxConnectionsDefault = 8;
   localparam int HeaderBytesDefault = 20;
   localparam logic [7:0] FlagSyn = 8'h02;
   localparam logic [7:0] OutSynAck = 8'h12;
   localparam logic [7:0] OutRst = 8'h04;
   localparam logic [7:0] OutAck = 8'h10;
   localparam logic [7:0] OutPshAck = 8'h18;
   localparam logic [7:0] InAck = 8'h10;
   localparam logic [7:0] InFinAck = 8'h11;
   localparam logic [7:0] InPshAck = 8'h18;
   localparam logic [15:0] EchoPortReset = 16'd7;
   localparam logic [15:0] WindowReset = 16'd8192;

   typedef enum logic [0:0] {
      CSR_ECHO_PORT = 1'b0,
      CSR_RECEIVE_WINDOW = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [31:0] remote_address;
      logic [15:0] remote_port;
      logic [15:0] local_port;
      logic [31:0] sequence_number;
      logic [31:0] acknowledge_number;
      logic [7:0]  segment_flags;
      logic [15:0] segment_length;
      logic [31:0] now_time;
   } req_word_type;

   typedef struct packed {
      logic [31:0] dest_address;
      logic [15:0] out_source_port;
      logic [15:0] out_dest_port;
      logic [31:0] out_sequence;
      logic [31:0] out_acknowledge;
      logic [7:0]  out_flags;
      logic [15:0] out_window;
      logic [15:0] payload_length;
      logic        last_result;
   } rsp_word_type;

   // Action kinds handed from the lookup side to the emit side.
   typedef enum logic [1:0] {
      ACT_RST,
      ACT_SYNACK,
      ACT_ACK,
      ACT_ECHO
   } act_kind_type;

   // One queued command: up to two words are produced from it.
   typedef struct packed {
      act_kind_type kind;
      logic [31:0]  addr;
      logic [15:0]  sport;
      logic [15:0]  dport;
      logic [31:0]  seq;
      logic [31:0]  ack;
      logic [15:0]  win;
      logic [15:0]  plen;
   } act_type;
endpackage

>>> rtl/tcp_echo_connection_engine.sv
// Top level of the TCP echo connection engine.
// Usage: drive req_word and raise start while busy is low; the header word
// is taken at that edge. busy stays high until every answer for the item has
// left, so the next start may follow right after busy falls.
// Answers appear on rsp_word for one cycle each, marked by rsp_valid; the
// receiver cannot stall them, so it must take each one on that cycle.
// last_result marks the final answer of an item; an echo gives two (ACK
// then PSH-ACK), dropped or pure ACK segments give none.
// Steps: the table compare over all entries is registered, then the update
// is applied and a command formed, then the command is pushed into the
// queue, then the first answer word is registered; for an echo the second
// answer follows in the next cycle. busy drops in the cycle after the last
// answer, or right after the command step when an item gives no answer.
// Registers on csr_: index 0 echo port, index 1 receive window; written when
// csr_write is high. The user must write only while idle (not enforced).
// Reset (synchronous, active high) frees all connections and restores
// echo port 7 and window 8192.
`timescale 1ns / 1ps
module tcp_echo_connection_engine import tce_pkg::*; #(
   parameter int MaxConnections = MaxConnectionsDefault,
   parameter int HeaderBytes = HeaderBytesDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         csr_write,
   input  logic [0:0]   csr_index,
   input  logic [15:0]  csr_data
);
   logic [15:0] echo_port_ff, window_ff;
   logic front_busy, back_busy, act_valid, q_room, q_ne, q_pop, accept;
   act_type act_word, head_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_port_ff <= EchoPortReset;
         window_ff <= WindowReset;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_ECHO_PORT: echo_port_ff <= csr_data;
            CSR_RECEIVE_WINDOW: window_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign busy = front_busy || back_busy || act_valid;
   assign accept = start && !busy;

   tce_front #(.MaxConnections(MaxConnections), .HeaderBytes(HeaderBytes)) u_front (
      .clock, .reset, .req_valid(accept), .req_word,
      .echo_port(echo_port_ff), .receive_window(window_ff),
      .q_room, .front_busy, .act_valid, .act_word
   );

   tce_queue u_queue (
      .clock, .reset, .push(act_valid), .push_word(act_word), .room(q_room),
      .not_empty(q_ne), .pop(q_pop), .head_word
   );

   tce_back u_back (
      .clock, .reset, .not_empty(q_ne), .head_word, .pop(q_pop),
      .back_busy, .rsp_valid, .rsp_word
   );

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("busy did not rise after accept");
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("answer without work");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last_result |=> rsp_valid) else $error("answer pair split");
endmodule

>>> rtl/tce_front.sv
// Connection table lookup, state update and classification into actions.
`timescale 1ns / 1ps
module tce_front import tce_pkg::*; #(
   parameter int MaxConnections = MaxConnectionsDefault,
   parameter int HeaderBytes = HeaderBytesDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_word_type req_word,
   input  logic [15:0]  echo_port,
   input  logic [15:0]  receive_window,
   input  logic         q_room,
   output logic         front_busy,
   output logic         act_valid,
   output act_type      act_word
);
   localparam int IdxW = (MaxConnections > 1) ? $clog2(MaxConnections) : 1;
   localparam logic [15:0] HdrLen = 16'(HeaderBytes);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC
   } state_type;

   state_type state_ff;
   req_word_type cur_ff;
   logic [MaxConnections-1:0] valid_ff;
   logic [MaxConnections-1:0] phase_ff;
   logic [31:0] addr_st [MaxConnections];
   logic [15:0] rport_st [MaxConnections];
   logic [15:0] lport_st [MaxConnections];
   logic [31:0] rnext_st [MaxConnections];
   logic [31:0] snext_st [MaxConnections];
   logic [31:0] suna_st [MaxConnections];

   // Registered scan results.
   logic hit_ff, free_ok_ff;
   logic [IdxW-1:0] hit_idx_ff, free_idx_ff;
   logic act_valid_ff;
   act_type act_ff;

   logic [MaxConnections-1:0] match_vec;
   logic hit_in, free_ok_in;
   logic [IdxW-1:0] hit_idx_in, free_idx_in;

   always_comb begin
      hit_in = 1'b0;
      free_ok_in = 1'b0;
      hit_idx_in = '0;
      free_idx_in = '0;
      for (int i = MaxConnections - 1; i >= 0; i--) begin
         match_vec[i] = valid_ff[i] && addr_st[i] == cur_ff.remote_address &&
                        rport_st[i] == cur_ff.remote_port &&
                        lport_st[i] == cur_ff.local_port;
         if (match_vec[i]) begin
            hit_in = 1'b1;
            hit_idx_in = IdxW'(i);
         end
         if (!valid_ff[i]) begin
            free_ok_in = 1'b1;
            free_idx_in = IdxW'(i);
         end
      end
   end

   logic [15:0] plen;
   logic [31:0] rn_hit;
   assign plen = (cur_ff.segment_length > HdrLen) ? cur_ff.segment_length - HdrLen : 16'd0;
   assign rn_hit = rnext_st[hit_idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         act_valid_ff <= 1'b0;
      end else begin
         act_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cur_ff <= req_word;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               hit_ff <= hit_in;
               hit_idx_ff <= hit_idx_in;
               free_ok_ff <= free_ok_in;
               free_idx_ff <= free_idx_in;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               // hold until the queue can take a command
               if (q_room) begin
                  state_ff <= S_IDLE;
                  act_ff.addr <= cur_ff.remote_address;
                  act_ff.sport <= cur_ff.local_port;
                  act_ff.dport <= cur_ff.remote_port;
                  if (!hit_ff) begin
                     if ((cur_ff.segment_flags & FlagSyn) != 8'd0 && free_ok_ff) begin
                        act_valid_ff <= 1'b1;
                        act_ff.plen <= 16'd0;
                        if (cur_ff.local_port != echo_port) begin
                           act_ff.kind <= ACT_RST;
                           act_ff.seq <= '0;
                           act_ff.ack <= '0;
                           act_ff.win <= '0;
                        end else begin
                           act_ff.kind <= ACT_SYNACK;
                           act_ff.seq <= cur_ff.now_time;
                           act_ff.ack <= cur_ff.sequence_number + 32'd1;
                           act_ff.win <= receive_window;
                           valid_ff[free_idx_ff] <= 1'b1;
                           phase_ff[free_idx_ff] <= 1'b0;
                           addr_st[free_idx_ff] <= cur_ff.remote_address;
                           rport_st[free_idx_ff] <= cur_ff.remote_port;
                           lport_st[free_idx_ff] <= cur_ff.local_port;
                           rnext_st[free_idx_ff] <= cur_ff.sequence_number + 32'd1;
                           suna_st[free_idx_ff] <= cur_ff.now_time;
                           snext_st[free_idx_ff] <= cur_ff.now_time + 32'd1;
                        end
                     end
                  end else if (cur_ff.segment_flags == InAck) begin
                     if (cur_ff.acknowledge_number > suna_st[hit_idx_ff]) begin
                        suna_st[hit_idx_ff] <= cur_ff.acknowledge_number;
                        phase_ff[hit_idx_ff] <= 1'b1;
                     end
                  end else if (phase_ff[hit_idx_ff]) begin
                     if (cur_ff.segment_flags == InFinAck) begin
                        act_valid_ff <= 1'b1;
                        act_ff.kind <= ACT_ACK;
                        act_ff.seq <= snext_st[hit_idx_ff];
                        act_ff.ack <= rn_hit + 32'd1;
                        act_ff.win <= receive_window;
                        act_ff.plen <= 16'd0;
                        rnext_st[hit_idx_ff] <= rn_hit + 32'd1;
                        valid_ff[hit_idx_ff] <= 1'b0;
                     end else if (cur_ff.segment_flags == InPshAck &&
                                  cur_ff.sequence_number == rn_hit) begin
                        act_valid_ff <= 1'b1;
                        act_ff.kind <= ACT_ECHO;
                        act_ff.seq <= snext_st[hit_idx_ff];
                        act_ff.ack <= rn_hit + 32'(plen);
                        act_ff.win <= receive_window;
                        act_ff.plen <= plen;
                        rnext_st[hit_idx_ff] <= rn_hit + 32'(plen);
                        snext_st[hit_idx_ff] <= snext_st[hit_idx_ff] + 32'(plen);
                     end
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign front_busy = (state_ff != S_IDLE);
   assign act_valid = act_valid_ff;
   assign act_word = act_ff;

   a_scan_then_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |=> state_ff == S_EXEC) else $error("scan not followed by exec");
   a_act_from_exec: assert property (@(posedge clock) disable iff (reset)
      act_valid_ff |-> $past(state_ff) == S_EXEC) else $error("action outside exec");
   a_req_only_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && req_valid |=> state_ff == S_SCAN) else $error("request lost");
endmodule

>>> rtl/tce_queue.sv
// Short command queue between the lookup side and the emit side.
`timescale 1ns / 1ps
module tce_queue import tce_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  act_type push_word,
   output logic    room,
   output logic    not_empty,
   input  logic    pop,
   output act_type head_word
);
   localparam int Depth = 2;
   act_type slot_ff [Depth];
   logic rd_ff, wr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) begin
            slot_ff[wr_ff] <= push_word;
            wr_ff <= ~wr_ff;
         end
         if (pop) rd_ff <= ~rd_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   // room counts a command already on its way in
   assign room = (count_ff == 2'd0) || (count_ff == 2'd1 && !push);
   assign not_empty = (count_ff != 2'd0);
   assign head_word = slot_ff[rd_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != 2'd2 || pop) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0) else $error("queue underflow");
endmodule

>>> rtl/tce_back.sv
// Turns queued commands into outgoing header words, one per cycle.
`timescale 1ns / 1ps
module tce_back import tce_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         not_empty,
   input  act_type      head_word,
   output logic         pop,
   output logic         back_busy,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);
   logic second_ff, valid_ff;
   rsp_word_type word_ff;
   logic is_echo;

   assign is_echo = (head_word.kind == ACT_ECHO);
   assign pop = not_empty && (!is_echo || second_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= not_empty;
         if (not_empty) begin
            second_ff <= is_echo && !second_ff;
            word_ff.dest_address <= head_word.addr;
            word_ff.out_source_port <= head_word.sport;
            word_ff.out_dest_port <= head_word.dport;
            word_ff.out_sequence <= head_word.seq;
            word_ff.out_acknowledge <= head_word.ack;
            word_ff.out_window <= head_word.win;
            word_ff.last_result <= pop;
            unique case (head_word.kind)
               ACT_RST: begin
                  word_ff.out_flags <= OutRst;
                  word_ff.payload_length <= '0;
               end
               ACT_SYNACK: begin
                  word_ff.out_flags <= OutSynAck;
                  word_ff.payload_length <= '0;
               end
               ACT_ACK: begin
                  word_ff.out_flags <= OutAck;
                  word_ff.payload_length <= '0;
               end
               ACT_ECHO: begin
                  word_ff.out_flags <= second_ff ? OutPshAck : OutAck;
                  word_ff.payload_length <= second_ff ? head_word.plen : 16'd0;
               end
               default: begin
                  word_ff.out_flags <= OutAck;
                  word_ff.payload_length <= '0;
               end
            endcase
         end
      end
   end

   assign back_busy = not_empty || valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_word = word_ff;
endmodule
